@@ src/adc_temperature_seven_segment_display_macros.svh @@
// Assertion macros shared by the temperature display RTL.
`ifndef ADC_TEMPERATURE_SEVEN_SEGMENT_DISPLAY_MACROS_SVH
`define ADC_TEMPERATURE_SEVEN_SEGMENT_DISPLAY_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every clock edge outside of reset.
`define ATSSD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition in one cycle implies another in the next cycle.
`define ATSSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ATSSD_ASSERT(lbl, prop, msg)
`define ATSSD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ src/atssd_pkg.sv @@
// Types, constants and the segment decoder of the temperature display.
package atssd_pkg;

    localparam int NUM_DIGITS  = 4;
    localparam int QUEUE_DEPTH = 2;

    // Command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // Error code shown above the range limit, most significant digit first
    localparam logic [3:0] ERR_DIGIT3 = 4'd3;
    localparam logic [3:0] ERR_DIGIT2 = 4'd6;
    localparam logic [3:0] ERR_DIGIT1 = 4'd6;
    localparam logic [3:0] ERR_DIGIT0 = 4'd0;

    localparam logic [1:0] LAST_IDX_FULL  = 2'd3;
    localparam logic [1:0] LAST_IDX_MID   = 2'd2;
    localparam logic [1:0] LAST_IDX_SHORT = 2'd1;
    localparam logic [1:0] POINT_POS      = 2'd1;
    localparam logic [7:0] SEG_POINT      = 8'h80;

    // One classified item between the front and the back
    typedef struct packed {
        logic       is_tick;
        logic       err;
        logic [1:0] last_idx;
        logic       thousands;
        logic [9:0] rest;
    } item_t;

    // Seven-segment pattern of one digit code
    function automatic logic [7:0] seg_pattern(input logic [3:0] code);
        logic [7:0] seg;
        unique case (code)
            4'd0:    seg = 8'h3F;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h5B;
            4'd3:    seg = 8'h4F;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6D;
            4'd6:    seg = 8'h7D;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7F;
            4'd9:    seg = 8'h6F;
            4'd10:   seg = 8'h40;
            default: seg = 8'hFF;
        endcase
        return seg;
    endfunction

endpackage

@@ src/atssd_front.sv @@
// Front end: accept items, scale samples to tenths of a degree and classify them.
module atssd_front (
    input  logic                in_valid,
    input  logic                queue_full,
    input  logic                cmd,
    input  logic [9:0]          adc_code,
    output logic                push,
    output atssd_pkg::item_t    item
);

    logic [19:0] scaled;
    logic [12:0] tenths;
    logic [10:0] value;
    logic [10:0] value_less;
    logic        thousands;

    // Accept whenever the queue has room
    assign push = in_valid && !queue_full;

    // Scale: code * 5000 / 1024 = code * 625 / 128
    assign scaled    = {10'd0, adc_code} * 20'd625;
    assign tenths    = scaled[19:7];
    assign value     = tenths[10:0];
    assign thousands = (value >= 11'd1000);
    assign value_less = value - 11'd1000;

    // Classify the item
    always_comb
    begin
        item.is_tick   = (cmd == atssd_pkg::CMD_TICK);
        item.err       = (tenths > 13'd1250);
        item.thousands = thousands;
        item.rest      = thousands ? value_less[9:0] : value[9:0];
        if (item.err || thousands)
        begin
            item.last_idx = atssd_pkg::LAST_IDX_FULL;
        end
        else if (value >= 11'd100)
        begin
            item.last_idx = atssd_pkg::LAST_IDX_MID;
        end
        else
        begin
            item.last_idx = atssd_pkg::LAST_IDX_SHORT;
        end
    end

endmodule

@@ src/atssd_queue.sv @@
// Short queue of classified items between the front and the back.
`include "adc_temperature_seven_segment_display_macros.svh"

module atssd_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  atssd_pkg::item_t    push_item,
    input  logic                pop,
    output logic                full,
    output logic                not_empty,
    output atssd_pkg::item_t    head
);

    localparam int PTR_W = $clog2(atssd_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(atssd_pkg::QUEUE_DEPTH + 1);

    atssd_pkg::item_t   entry_reg [atssd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full      = (count_reg == CNT_W'(atssd_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(atssd_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(atssd_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold the payload of each slot
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    `ATSSD_ASSERT(a_no_overflow, count_reg <= CNT_W'(atssd_pkg::QUEUE_DEPTH), "queue overflow")
    `ATSSD_ASSERT(a_no_underflow, !(pop && !not_empty), "pop from empty queue")
    `ATSSD_ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1, "count")

endmodule

@@ src/atssd_back.sv @@
// Back end: store digits from samples and scan the display on ticks.
`include "adc_temperature_seven_segment_display_macros.svh"

module atssd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  atssd_pkg::item_t    item,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [3:0]          digit_enable,
    output logic [7:0]          segments
);

    logic [3:0]  digit_reg [atssd_pkg::NUM_DIGITS];
    logic [1:0]  last_reg;
    logic [1:0]  pos_reg;
    logic [1:0]  pos_next;
    logic        point_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [3:0]  enable_reg;
    logic [7:0]  seg_reg;
    logic [7:0]  seg_next;

    logic        out_free;
    logic        take_tick;
    logic        take_sample;
    logic [15:0] hund_prod;
    logic [3:0]  hundreds;
    logic [10:0] hund_val;
    logic [10:0] below_hund;
    logic [6:0]  rem_hund;
    logic [14:0] tens_prod;
    logic [3:0]  tens;
    logic [6:0]  tens_val;
    logic [6:0]  units_full;

    // Pop a sample at once, a tick only when the output slot frees up
    assign out_free    = !out_valid_reg || !out_stall;
    assign pop         = item_valid && (!item.is_tick || out_free);
    assign take_tick   = pop && item.is_tick;
    assign take_sample = pop && !item.is_tick;

    // Split the remainder below a thousand into decimal digits
    assign hund_prod  = {6'd0, item.rest} * 16'd41;
    assign hundreds   = hund_prod[15:12];
    assign hund_val   = {7'd0, hundreds} * 11'd100;
    assign below_hund = {1'b0, item.rest} - hund_val;
    assign rem_hund   = below_hund[6:0];
    assign tens_prod  = {8'd0, rem_hund} * 15'd205;
    assign tens       = tens_prod[14:11];
    assign tens_val   = {3'd0, tens} * 7'd10;
    assign units_full = rem_hund - tens_val;

    // Advance the scan position, wrapping after the last digit
    assign pos_next = (pos_reg >= last_reg) ? 2'd0 : pos_reg + 2'd1;

    always_comb
    begin
        seg_next = atssd_pkg::seg_pattern(digit_reg[pos_next]);
        if (pos_next == atssd_pkg::POINT_POS && point_reg)
        begin
            seg_next = seg_next | atssd_pkg::SEG_POINT;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take_tick)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < atssd_pkg::NUM_DIGITS; k++)
            begin
                digit_reg[k] <= 4'd0;
            end
            last_reg      <= atssd_pkg::LAST_IDX_FULL;
            pos_reg       <= 2'd0;
            point_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take_tick)
            begin
                pos_reg <= pos_next;
            end
            if (take_sample)
            begin
                last_reg <= item.last_idx;
                if (item.err)
                begin
                    digit_reg[3] <= atssd_pkg::ERR_DIGIT3;
                    digit_reg[2] <= atssd_pkg::ERR_DIGIT2;
                    digit_reg[1] <= atssd_pkg::ERR_DIGIT1;
                    digit_reg[0] <= atssd_pkg::ERR_DIGIT0;
                    point_reg    <= 1'b0;
                end
                else
                begin
                    digit_reg[3] <= {3'd0, item.thousands};
                    digit_reg[2] <= hundreds;
                    digit_reg[1] <= tens;
                    digit_reg[0] <= units_full[3:0];
                    point_reg    <= 1'b1;
                end
            end
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (take_tick)
        begin
            enable_reg <= 4'b0001 << pos_next;
            seg_reg    <= seg_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign digit_enable = enable_reg;
    assign segments     = seg_reg;

    `ATSSD_ASSERT(a_enable_onehot, !out_valid_reg || $onehot(enable_reg), "select not one-hot")
    `ATSSD_ASSERT(a_point_units, !(out_valid_reg && seg_reg[7]) || enable_reg == 4'b0010, "point")
    `ATSSD_ASSERT_NEXT(a_tick_shows, take_tick, out_valid_reg, "tick lost")

endmodule

@@ src/adc_temperature_seven_segment_display.sv @@
// A scan tick's result is written into the queue and then taken into the output register.
// A sample yields no result.
// Throughput: one item per cycle while the queue is not full; a tick waits only for the output register.
// Items pass through a two-entry queue that lets input and output stall separately.
// Reset (rst_n low, asynchronous) clears digits, scan position and point mode, sets the
// last digit to 3 and empties the queue and output register.
module adc_temperature_seven_segment_display (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [9:0]  adc_code,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  digit_enable,
    output logic [7:0]  segments
);

    logic             queue_full;
    logic             push;
    logic             pop;
    logic             queue_valid;
    atssd_pkg::item_t new_item;
    atssd_pkg::item_t head_item;

    assign in_stall = queue_full;

    atssd_front u_front (
        .in_valid   (in_valid),
        .queue_full (queue_full),
        .cmd        (cmd),
        .adc_code   (adc_code),
        .push       (push),
        .item       (new_item)
    );

    atssd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (new_item),
        .pop        (pop),
        .full       (queue_full),
        .not_empty  (queue_valid),
        .head       (head_item)
    );

    atssd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (queue_valid),
        .item         (head_item),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .digit_enable (digit_enable),
        .segments     (segments)
    );

endmodule

@@ sim/tb.sv @@
// Self-checking testbench of the temperature display driver with its own scan predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 10;

    typedef struct packed {
        logic       cmd;
        logic [9:0] code;
    } disp_item_t;

    typedef struct packed {
        logic [3:0] enable;
        logic [7:0] seg;
    } scan_out_t;

    // Segment patterns a..g, point in bit 7
    localparam logic [7:0] SEG_CODES [16] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
        8'h7F, 8'h6F, 8'h40, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF
    };

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic       cmd;
    logic [9:0] adc_code;
    logic       out_valid;
    logic       out_stall;
    logic [3:0] digit_enable;
    logic [7:0] segments;

    disp_item_t pending_items[$];
    scan_out_t  expected_scans[$];
    disp_item_t shown_item;

    // Predictor state
    logic [3:0] shown_digits [atssd_pkg::NUM_DIGITS];
    logic [1:0] top_index;
    logic [1:0] scan_pos;
    logic       point_on;

    int idle_pct;
    int stall_pct;
    int errors;
    int items_in;
    int scans_checked;
    int quiet_cycles;

    adc_temperature_seven_segment_display dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .adc_code     (adc_code),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .digit_enable (digit_enable),
        .segments     (segments)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("tb: mismatch %s: got 0x%0h, want 0x%0h (result %0d)",
                 what, got, want, scans_checked);
    endtask

    // Write a value as four decimal digits, least significant first
    task automatic store_tenths(input int value);
        int v;
        v = value;
        for (int k = 0; k < atssd_pkg::NUM_DIGITS; k++)
        begin
            shown_digits[k] = 4'(v % 10);
            v = v / 10;
        end
    endtask

    // Advance the predictor by one accepted transfer
    task automatic predict_display(input disp_item_t it);
        int        tenths;
        scan_out_t res;
        if (it.cmd == atssd_pkg::CMD_SAMPLE)
        begin
            tenths = (int'(it.code) * 5000) >> 10;
            if (tenths > 1250)
            begin
                shown_digits[3] = atssd_pkg::ERR_DIGIT3;
                shown_digits[2] = atssd_pkg::ERR_DIGIT2;
                shown_digits[1] = atssd_pkg::ERR_DIGIT1;
                shown_digits[0] = atssd_pkg::ERR_DIGIT0;
                top_index       = atssd_pkg::LAST_IDX_FULL;
                point_on        = 1'b0;
            end
            else
            begin
                if (tenths >= 1000)
                    top_index = atssd_pkg::LAST_IDX_FULL;
                else if (tenths >= 100)
                    top_index = atssd_pkg::LAST_IDX_MID;
                else
                    top_index = atssd_pkg::LAST_IDX_SHORT;
                store_tenths(tenths);
                point_on = 1'b1;
            end
        end
        else
        begin
            if (scan_pos >= top_index)
                scan_pos = 2'd0;
            else
                scan_pos = scan_pos + 2'd1;
            res.seg = SEG_CODES[shown_digits[scan_pos]];
            if (scan_pos == atssd_pkg::POINT_POS && point_on)
                res.seg = res.seg | atssd_pkg::SEG_POINT;
            res.enable = 4'b0001 << scan_pos;
            expected_scans.push_back(res);
        end
    endtask

    function automatic disp_item_t make_item(input logic c, input int code);
        disp_item_t it;
        it.cmd  = c;
        it.code = 10'(code);
        return it;
    endfunction

    // Pick a converter code: in range, out of range, or near a boundary
    function automatic int pick_code();
        int sel;
        int edges [10] = '{0, 1, 20, 21, 204, 205, 256, 257, 512, 1023};
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return $urandom_range(0, 256);
        else if (sel < 7)
            return $urandom_range(257, 1023);
        else
            return edges[$urandom_range(0, 9)];
    endfunction

    // Queue random traffic: bursts of ticks separated by samples
    task automatic queue_random(input int count);
        int n;
        n = 0;
        while (n < count)
        begin
            if ($urandom_range(0, 99) < 25)
            begin
                pending_items.push_back(make_item(atssd_pkg::CMD_SAMPLE, pick_code()));
                n++;
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    pending_items.push_back(make_item(atssd_pkg::CMD_TICK,
                                                      $urandom_range(0, 1023)));
                    n++;
                end
            end
        end
    endtask

    // Hold until every queued transfer is in and every result is out
    task automatic wait_drained();
        while (pending_items.size() != 0 || in_valid || expected_scans.size() != 0)
            @(posedge clk);
    endtask

    // Driver: present queued items, hold a stalled payload
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cmd      <= atssd_pkg::CMD_SAMPLE;
            adc_code <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_display(shown_item);
                items_in++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    shown_item = pending_items.pop_front();
                    in_valid   <= 1'b1;
                    cmd        <= shown_item.cmd;
                    adc_code   <= shown_item.code;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transfer and drive random stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_scans.size() == 0)
                begin
                    report_mismatch("unexpected result", {digit_enable, segments}, 0);
                end
                else
                begin
                    automatic scan_out_t want = expected_scans.pop_front();
                    if (digit_enable !== want.enable)
                        report_mismatch("digit_enable", digit_enable, want.enable);
                    if (segments !== want.seg)
                        report_mismatch("segments", segments, want.seg);
                end
                scans_checked++;
            end
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: watchdog expired after %0d idle cycles", quiet_cycles);
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        errors        = 0;
        items_in      = 0;
        scans_checked = 0;
        quiet_cycles  = 0;
        idle_pct      = 0;
        stall_pct     = 0;
        for (int k = 0; k < atssd_pkg::NUM_DIGITS; k++)
            shown_digits[k] = 4'd0;
        top_index = atssd_pkg::LAST_IDX_FULL;
        scan_pos  = 2'd0;
        point_on  = 1'b0;

        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset digits across a full scan, then a wrap past a lowered last digit
        repeat (7) pending_items.push_back(make_item(atssd_pkg::CMD_TICK, 0));
        pending_items.push_back(make_item(atssd_pkg::CMD_SAMPLE, 20));
        pending_items.push_back(make_item(atssd_pkg::CMD_TICK, 1023));
        pending_items.push_back(make_item(atssd_pkg::CMD_TICK, 0));
        // Range limit exactly, then just above it and the top code
        pending_items.push_back(make_item(atssd_pkg::CMD_SAMPLE, 256));
        repeat (2) pending_items.push_back(make_item(atssd_pkg::CMD_TICK, 0));
        pending_items.push_back(make_item(atssd_pkg::CMD_SAMPLE, 257));
        pending_items.push_back(make_item(atssd_pkg::CMD_SAMPLE, 1023));
        repeat (4) pending_items.push_back(make_item(atssd_pkg::CMD_TICK, 0));
        // Digit-count boundaries at ten and one hundred degrees
        pending_items.push_back(make_item(atssd_pkg::CMD_SAMPLE, 21));
        pending_items.push_back(make_item(atssd_pkg::CMD_TICK, 0));
        pending_items.push_back(make_item(atssd_pkg::CMD_SAMPLE, 204));
        pending_items.push_back(make_item(atssd_pkg::CMD_SAMPLE, 205));
        repeat (2) pending_items.push_back(make_item(atssd_pkg::CMD_TICK, 0));
        wait_drained();

        // Random phases: no idling, sender idle, receiver stalling, both
        for (int phase = 0; phase < 4; phase++)
        begin
            @(negedge clk);
            idle_pct  = (phase == 1) ? 74 : (phase == 3) ? 12 : 0;
            stall_pct = (phase == 2) ? 74 : (phase == 3) ? 12 : 0;
            queue_random(135);
            wait_drained();
        end

        @(negedge clk);
        idle_pct  = 0;
        stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("tb: %0d items transferred, %0d scan results checked", items_in,
                 scans_checked);
        $display("tb: covered error range, digit-count limits and four idle patterns");
        if (errors == 0 && expected_scans.size() == 0)
        begin
            $display("tb: done, clean");
        end
        else
        begin
            $display("tb: %0d mismatches, %0d results missing", errors,
                     expected_scans.size());
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
